// ===== sv/vtqp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vtqp_pkg
// Shared widths, stage counts, register codes, types and byte quantizers for
// the vertex transform, quantize and pack pipeline.
// ----------------------------------------------------------------------------
package vtqp_pkg;

	localparam int IN_W  = 472;
	localparam int OUT_W = 320;

	localparam int L2_W        = 61;
	localparam int ROOT_W      = L2_W + 1;
	localparam int LEN_W       = 31;
	localparam int NUM_W       = 47;
	localparam int DEN_W       = 32;
	localparam int QUO_W       = 15;

	localparam int NMAT_STAGES = 4;
	localparam int SQRT_STAGES = ROOT_W / 2;
	localparam int PREP_STAGES = 1;
	localparam int DIV_STAGES  = QUO_W;
	localparam int XF_STAGES   = 3;
	localparam int PIPE_DEPTH  = NMAT_STAGES + SQRT_STAGES + PREP_STAGES + DIV_STAGES;
	localparam int SB_DELAY    = PIPE_DEPTH - XF_STAGES;

	localparam logic [1:0] MODE_SKIN  = 2'd0;
	localparam logic [1:0] MODE_PLAIN = 2'd1;
	localparam logic [1:0] MODE_LMAP  = 2'd2;

	localparam logic [2:0] REG_MODE    = 3'd0;
	localparam logic [2:0] REG_ROW_X   = 3'd1;
	localparam logic [2:0] REG_ROW_Y   = 3'd2;
	localparam logic [2:0] REG_ROW_Z   = 3'd3;
	localparam logic [2:0] REG_TRANS_XY = 3'd4;
	localparam logic [2:0] REG_TRANS_Z = 3'd5;
	localparam logic [2:0] REG_NMAT_LO = 3'd6;
	localparam logic [2:0] REG_NMAT_HI = 3'd7;

	typedef logic [2:0][31:0] svec_t;

	typedef struct packed {
		logic zero;
		logic ovf;
		logic neg;
	} tag_t;

	typedef struct packed {
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [63:0] uv;
		logic [31:0] color;
		logic [31:0] color2;
		logic        tneg;
	} side_t;

	function automatic logic [7:0] sat_byte(input logic [15:0] raw);
		logic [22:0] prod;
		logic [8:0]  q;
		prod = {8'd0, raw[14:0]} * 23'd255;
		q = prod[22:14];
		if (raw[15])
			return 8'd0;
		else if (q[8])
			return 8'hFF;
		else
			return q[7:0];
	endfunction

	function automatic logic [7:0] wrap_byte(input logic [15:0] raw);
		logic [16:0] mag;
		logic [24:0] prod;
		logic [7:0]  m;
		mag = raw[15] ? 17'(~{1'b1, raw} + 17'd1) : {1'b0, raw};
		prod = {8'd0, mag} * 25'd255;
		m = prod[21:14];
		return raw[15] ? 8'(~m + 8'd1) : m;
	endfunction

	function automatic logic [15:0] uv2_quant(input logic [24:0] raw);
		logic [39:0] prod;
		logic [23:0] q;
		prod = {16'd0, raw[23:0]} * 40'd65535;
		q = prod[39:16];
		if (raw[24])
			return 16'd0;
		else if (q[23:16] != 8'd0)
			return 16'hFFFF;
		else
			return q[15:0];
	endfunction

endpackage
`default_nettype wire

// ===== sv/vtqp_nmat.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vtqp_nmat
// Normal-matrix product and squared length, four register stages.
// ----------------------------------------------------------------------------
module vtqp_nmat import vtqp_pkg::*; (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [125:0]     nmat,
	input  wire logic [47:0]      vec,
	output svec_t                 s,
	output logic [L2_W-1:0]       l2
);

	logic signed [29:0] prod_s1 [9];
	svec_t              s_s2;
	svec_t              s_s3;
	svec_t              s_s4;
	logic [29:0]        a_s2 [3];
	logic [59:0]        sq_s3 [3];
	logic [L2_W-1:0]    l2_s4;
	logic signed [31:0] sum [3];
	logic [31:0]        mag [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sum[r] = 32'(prod_s1[3*r]) + 32'(prod_s1[3*r+1]) + 32'(prod_s1[3*r+2]);
			mag[r] = sum[r][31] ? 32'(-sum[r]) : 32'(sum[r]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s1[3*r+c] <= $signed(nmat[14*(3*r+c) +: 14]) * $signed(vec[16*c +: 16]);
				end
				s_s2[r]  <= sum[r];
				a_s2[r]  <= mag[r][29:0];
				sq_s3[r] <= a_s2[r] * a_s2[r];
			end
			s_s3  <= s_s2;
			s_s4  <= s_s3;
			l2_s4 <= L2_W'(sq_s3[0]) + L2_W'(sq_s3[1]) + L2_W'(sq_s3[2]);
		end
	end

	assign s  = s_s4;
	assign l2 = l2_s4;

endmodule
`default_nettype wire

// ===== sv/vtqp_isqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vtqp_isqrt
// Pipelined integer square root, one result bit per stage, with the
// vector components carried alongside.
// ----------------------------------------------------------------------------
module vtqp_isqrt import vtqp_pkg::*; (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [L2_W-1:0]  l2,
	input  wire svec_t            s_in,
	output logic [LEN_W-1:0]      len,
	output svec_t                 s_out
);

	logic [ROOT_W-1:0] rem_s  [SQRT_STAGES];
	logic [ROOT_W-1:0] root_s [SQRT_STAGES];
	svec_t             sv_s   [SQRT_STAGES];

	for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
		localparam int K = SQRT_STAGES - 1 - g;
		logic [ROOT_W-1:0] rem_in;
		logic [ROOT_W-1:0] root_in;
		svec_t             sv_in;
		logic [ROOT_W-1:0] bitv;
		logic [ROOT_W-1:0] trial;

		if (g == 0) begin : g_first
			assign rem_in  = ROOT_W'(l2);
			assign root_in = '0;
			assign sv_in   = s_in;
		end else begin : g_next
			assign rem_in  = rem_s[g-1];
			assign root_in = root_s[g-1];
			assign sv_in   = sv_s[g-1];
		end

		assign bitv  = ROOT_W'(1) << (2 * K);
		assign trial = root_in + bitv;

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					rem_s[g]  <= rem_in - trial;
					root_s[g] <= (root_in >> 1) + bitv;
				end else begin
					rem_s[g]  <= rem_in;
					root_s[g] <= root_in >> 1;
				end
				sv_s[g] <= sv_in;
			end
		end
	end

	assign len   = root_s[SQRT_STAGES-1][LEN_W-1:0];
	assign s_out = sv_s[SQRT_STAGES-1];

endmodule
`default_nettype wire

// ===== sv/vtqp_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vtqp_div
// Pipelined restoring divider, one quotient bit per stage, with a tag
// carried alongside.
// ----------------------------------------------------------------------------
module vtqp_div import vtqp_pkg::*; (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	input  wire tag_t             tag_in,
	output logic [QUO_W-1:0]      quo,
	output tag_t                  tag_out
);

	logic [NUM_W-1:0] rem_s [DIV_STAGES];
	logic [DEN_W-1:0] den_s [DIV_STAGES];
	logic [QUO_W-1:0] quo_s [DIV_STAGES];
	tag_t             tag_s [DIV_STAGES];

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		localparam int I = DIV_STAGES - 1 - g;
		logic [NUM_W-1:0] rem_in;
		logic [DEN_W-1:0] den_in;
		logic [QUO_W-1:0] quo_in;
		tag_t             tag_in_g;
		logic [NUM_W-1:0] shifted;

		if (g == 0) begin : g_first
			assign rem_in   = num;
			assign den_in   = den;
			assign quo_in   = '0;
			assign tag_in_g = tag_in;
		end else begin : g_next
			assign rem_in   = rem_s[g-1];
			assign den_in   = den_s[g-1];
			assign quo_in   = quo_s[g-1];
			assign tag_in_g = tag_s[g-1];
		end

		assign shifted = NUM_W'(den_in) << I;

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= shifted) begin
					rem_s[g] <= rem_in - shifted;
					quo_s[g] <= quo_in | (QUO_W'(1) << I);
				end else begin
					rem_s[g] <= rem_in;
					quo_s[g] <= quo_in;
				end
				den_s[g] <= den_in;
				tag_s[g] <= tag_in_g;
			end
		end
	end

	assign quo     = quo_s[DIV_STAGES-1];
	assign tag_out = tag_s[DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== sv/vtqp_xform.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vtqp_xform
// Affine position transform and colour word packing, three register stages.
// ----------------------------------------------------------------------------
module vtqp_xform import vtqp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [1:0]  mode,
	input  wire logic [63:0] row_x,
	input  wire logic [63:0] row_y,
	input  wire logic [63:0] row_z,
	input  wire logic [63:0] trans_xy,
	input  wire logic [31:0] trans_z,
	input  wire logic [31:0] pos_x,
	input  wire logic [31:0] pos_y,
	input  wire logic [31:0] pos_z,
	input  wire logic [63:0] uv_in,
	input  wire logic [49:0] uv2_in,
	input  wire logic [31:0] bone_ids,
	input  wire logic [63:0] bone_weights_in,
	input  wire logic [63:0] color_in,
	input  wire logic        tangent_negative,
	output side_t            side
);

	logic signed [47:0] prod_s1 [9];
	logic [43:0]        acc_s2 [3];
	side_t              side_s1;
	side_t              side_s2;
	side_t              side_s3;
	logic [63:0]        rows [3];
	logic [31:0]        pos [3];
	logic [31:0]        col;
	logic [31:0]        col2;
	logic [15:0]        u_q;
	logic [15:0]        v_q;

	assign rows[0] = row_x;
	assign rows[1] = row_y;
	assign rows[2] = row_z;
	assign pos[0]  = pos_x;
	assign pos[1]  = pos_y;
	assign pos[2]  = pos_z;
	assign u_q     = uv2_quant(uv2_in[24:0]);
	assign v_q     = uv2_quant(uv2_in[49:25]);

	always_comb begin
		col  = '0;
		col2 = '0;
		case (mode)
			MODE_SKIN: begin
				col = bone_ids;
				for (int c = 0; c < 4; c++)
					col2[8*c +: 8] = sat_byte(bone_weights_in[16*c +: 16]);
			end
			MODE_LMAP: begin
				col = {v_q, u_q};
				for (int c = 0; c < 4; c++)
					col2[8*c +: 8] = wrap_byte(color_in[16*c +: 16]);
			end
			default: begin
				for (int c = 0; c < 4; c++)
					col2[8*c +: 8] = sat_byte(color_in[16*c +: 16]);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++)
					prod_s1[3*r+c] <= $signed(rows[r][16*c +: 16]) * $signed(pos[c]);
				acc_s2[r] <= 44'(prod_s1[3*r]) + 44'(prod_s1[3*r+1]) + 44'(prod_s1[3*r+2]);
			end
			side_s1 <= '{pos_x: '0, pos_y: '0, pos_z: '0, uv: uv_in, color: col,
				color2: col2, tneg: tangent_negative};
			side_s2 <= side_s1;
			side_s3 <= '{pos_x: acc_s2[0][43:12] + trans_xy[31:0],
				pos_y: acc_s2[1][43:12] + trans_xy[63:32],
				pos_z: acc_s2[2][43:12] + trans_z,
				uv: side_s2.uv, color: side_s2.color, color2: side_s2.color2,
				tneg: side_s2.tneg};
		end
	end

	assign side = side_s3;

endmodule
`default_nettype wire

// ===== sv/vertex_transform_quantize_pack_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_transform_quantize_pack_top
// Transforms, renormalizes, quantizes and packs one vertex per item.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals                           Width
// s_axis    in         tvalid, tready, tdata             472
// m_axis    out        tvalid, tready, tdata             320
// cfg       in         valid, ready, index, data         3 + 64
//
// One item is accepted per cycle while the output buffer has a free entry;
// m_axis_tvalid rises once the item has passed the pipeline into the output register.
// The pipeline is made of four matrix stages, the 31-stage square root, one
// scaling stage and the 15-stage dividers.
// Reset loads the register defaults and empties the pipeline; no sweep follows.
// The whole pipeline advances together; a two-entry output buffer lets one
// more item in while a result waits, and tready drops when the buffer fills.
// ----------------------------------------------------------------------------
module vertex_transform_quantize_pack_top import vtqp_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	// pos_x, pos_y, pos_z, normal_in, tangent_in, tangent_negative, uv_in,
	// uv2_in, bone_ids, bone_weights_in, color_in, zero fill
	input  wire logic [IN_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	// out_pos_x, out_pos_y, out_pos_z, out_uv, out_normal, out_tangent,
	// out_color, out_color2
	output logic [OUT_W-1:0]      m_axis_tdata,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [2:0]       cfg_index,
	input  wire logic [63:0]      cfg_data
);

	logic [1:0]  mode_q;
	logic [63:0] row_x_q;
	logic [63:0] row_y_q;
	logic [63:0] row_z_q;
	logic [63:0] trans_xy_q;
	logic [31:0] trans_z_q;
	logic [63:0] nmat_lo_q;
	logic [63:0] nmat_hi_q;
	logic [125:0] nmat;

	logic        adv;
	logic        vld_s [PIPE_DEPTH];
	side_t       side_s [SB_DELAY];
	side_t       xf_side;

	svec_t            ns_s4;
	svec_t            ts_s4;
	logic [L2_W-1:0]  nl2_s4;
	logic [L2_W-1:0]  tl2_s4;
	svec_t            ns_sq;
	svec_t            ts_sq;
	logic [LEN_W-1:0] nlen_sq;
	logic [LEN_W-1:0] tlen_sq;

	logic [NUM_W-1:0] nnum_s36 [3];
	logic [DEN_W-1:0] nden_s36 [3];
	tag_t             ntag_s36 [3];
	logic [NUM_W-1:0] tnum_s36 [3];
	logic [DEN_W-1:0] tden_s36 [3];
	tag_t             ttag_s36 [3];

	logic [QUO_W-1:0] nquo [3];
	tag_t             ntag [3];
	logic [QUO_W-1:0] tquo [3];
	tag_t             ttag [3];

	logic [47:0]      nrm;
	logic [47:0]      tan;
	logic [OUT_W-1:0] res;
	logic             out_vld_q;
	logic             skid_vld_q;
	logic [OUT_W-1:0] out_data_q;
	logic [OUT_W-1:0] skid_data_q;
	logic             pop;
	logic             arrive;

	assign cfg_ready = 1'b1;
	assign nmat      = {nmat_hi_q[61:0], nmat_lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_PLAIN;
			row_x_q    <= 64'h0000_0000_0000_1000;
			row_y_q    <= 64'h0000_0000_1000_0000;
			row_z_q    <= 64'h0000_1000_0000_0000;
			trans_xy_q <= '0;
			trans_z_q  <= '0;
			nmat_lo_q  <= '0;
			nmat_hi_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MODE:     mode_q     <= cfg_data[1:0];
				REG_ROW_X:    row_x_q    <= cfg_data;
				REG_ROW_Y:    row_y_q    <= cfg_data;
				REG_ROW_Z:    row_z_q    <= cfg_data;
				REG_TRANS_XY: trans_xy_q <= cfg_data;
				REG_TRANS_Z:  trans_z_q  <= cfg_data[31:0];
				REG_NMAT_LO:  nmat_lo_q  <= cfg_data;
				REG_NMAT_HI:  nmat_hi_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// The pipeline moves whenever the output buffer has a free entry.
	assign adv           = !skid_vld_q;
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIPE_DEPTH; i++)
				vld_s[i] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= s_axis_tvalid;
			for (int i = 1; i < PIPE_DEPTH; i++)
				vld_s[i] <= vld_s[i-1];
		end
	end

	vtqp_xform u_xform (
		.clk              (clk),
		.en               (adv),
		.mode             (mode_q),
		.row_x            (row_x_q),
		.row_y            (row_y_q),
		.row_z            (row_z_q),
		.trans_xy         (trans_xy_q),
		.trans_z          (trans_z_q),
		.pos_x            (s_axis_tdata[31:0]),
		.pos_y            (s_axis_tdata[63:32]),
		.pos_z            (s_axis_tdata[95:64]),
		.uv_in            (s_axis_tdata[256:193]),
		.uv2_in           (s_axis_tdata[306:257]),
		.bone_ids         (s_axis_tdata[338:307]),
		.bone_weights_in  (s_axis_tdata[402:339]),
		.color_in         (s_axis_tdata[466:403]),
		.tangent_negative (s_axis_tdata[192]),
		.side             (xf_side)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= xf_side;
			for (int i = 1; i < SB_DELAY; i++)
				side_s[i] <= side_s[i-1];
		end
	end

	vtqp_nmat u_nmat_n (
		.clk  (clk),
		.en   (adv),
		.nmat (nmat),
		.vec  (s_axis_tdata[143:96]),
		.s    (ns_s4),
		.l2   (nl2_s4)
	);

	vtqp_nmat u_nmat_t (
		.clk  (clk),
		.en   (adv),
		.nmat (nmat),
		.vec  (s_axis_tdata[191:144]),
		.s    (ts_s4),
		.l2   (tl2_s4)
	);

	vtqp_isqrt u_isqrt_n (
		.clk   (clk),
		.en    (adv),
		.l2    (nl2_s4),
		.s_in  (ns_s4),
		.len   (nlen_sq),
		.s_out (ns_sq)
	);

	vtqp_isqrt u_isqrt_t (
		.clk   (clk),
		.en    (adv),
		.l2    (tl2_s4),
		.s_in  (ts_s4),
		.len   (tlen_sq),
		.s_out (ts_sq)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				logic [29:0]        a;
				logic signed [33:0] tsum;
				logic [31:0]        two_len;
				logic [31:0]        tn;
				a = ns_sq[r][31] ? 30'(-$signed(ns_sq[r])) : ns_sq[r][29:0];
				nnum_s36[r] <= {2'b0, a, 15'd0} - NUM_W'(a);
				nden_s36[r] <= DEN_W'(nlen_sq);
				ntag_s36[r] <= '{zero: (nlen_sq == '0),
					ovf: (({2'b0, a, 15'd0} - NUM_W'(a)) >= {1'b0, nlen_sq, 15'd0}),
					neg: ns_sq[r][31]};

				two_len = {tlen_sq, 1'b0};
				tsum = $signed({{2{ts_sq[r][31]}}, ts_sq[r]}) + $signed({3'b0, tlen_sq});
				if (tsum[33])
					tn = '0;
				else if (tsum[32:0] > {1'b0, two_len})
					tn = two_len;
				else
					tn = tsum[31:0];
				tnum_s36[r] <= {tn, 15'd0} - NUM_W'(tn);
				tden_s36[r] <= two_len;
				ttag_s36[r] <= '{zero: (tlen_sq == '0), ovf: 1'b0, neg: 1'b0};
			end
		end
	end

	for (genvar r = 0; r < 3; r++) begin : g_lane
		vtqp_div u_div_n (
			.clk     (clk),
			.en      (adv),
			.num     (nnum_s36[r]),
			.den     (nden_s36[r]),
			.tag_in  (ntag_s36[r]),
			.quo     (nquo[r]),
			.tag_out (ntag[r])
		);

		vtqp_div u_div_t (
			.clk     (clk),
			.en      (adv),
			.num     (tnum_s36[r]),
			.den     (tden_s36[r]),
			.tag_in  (ttag_s36[r]),
			.quo     (tquo[r]),
			.tag_out (ttag[r])
		);
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			logic [15:0] mag;
			mag = ntag[r].ovf ? 16'h7FFF : {1'b0, nquo[r]};
			if (ntag[r].zero)
				nrm[16*r +: 16] = '0;
			else if (ntag[r].neg)
				nrm[16*r +: 16] = 16'(16'd0 - mag);
			else
				nrm[16*r +: 16] = mag;
			tan[16*r +: 15] = ttag[r].zero ? 15'd16383 : tquo[r];
			tan[16*r + 15]  = 1'b0;
		end
		tan[47] = side_s[SB_DELAY-1].tneg;
		res = {side_s[SB_DELAY-1].color2, side_s[SB_DELAY-1].color, tan, nrm,
			side_s[SB_DELAY-1].uv, side_s[SB_DELAY-1].pos_z,
			side_s[SB_DELAY-1].pos_y, side_s[SB_DELAY-1].pos_x};
	end

	assign pop    = out_vld_q && m_axis_tready;
	assign arrive = adv && vld_s[PIPE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (pop)
				skid_vld_q <= 1'b0;
		end else if (arrive) begin
			if (!out_vld_q || pop)
				out_vld_q <= 1'b1;
			else
				skid_vld_q <= 1'b1;
		end else if (pop) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (pop)
				out_data_q <= skid_data_q;
		end else if (arrive) begin
			if (!out_vld_q || pop)
				out_data_q <= res;
			else
				skid_data_q <= res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("buffered result without a result at the output");

	a_arrival_lands: assert property (@(posedge clk) disable iff (!arst_n)
		arrive |=> out_vld_q)
		else $error("finished item did not reach the output register");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_vld_q && m_axis_tready) |=> (out_vld_q && !skid_vld_q))
		else $error("buffered result not moved to the output after a take");

endmodule
`default_nettype wire
